// ----- rtl/core/bb3_pkg.sv -----
package bb3_pkg;

  localparam int MaxLine = 1024;
  localparam int ColW = $clog2(MaxLine);
  localparam int WidthW = 11;
  localparam int HeightW = 13;
  localparam int HeightLimit = 4096;
  localparam int RowW = 13;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef logic [23:0] pixel_t;

  // Neighbor selection for one result: row and column masks.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic [3:0] count;
  } nbr_mask_t;

  // Round-half-up mean of a sum of up to nine 8-bit values.
  // count is 1, 2, 3, 4, 6 or 9; 3, 6 and 9 use a reciprocal multiply.
  function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] count);
    logic [13:0] num;
    logic [31:0] prod;
    logic [13:0] q;
    num = {sum, 1'b0} + 14'(count);
    prod = '0;
    q = '0;
    unique case (count)
      4'd1: q = num >> 1;
      4'd2: q = num >> 2;
      4'd4: q = num >> 3;
      4'd3: begin
        prod = 32'(num) * 32'd10923;
        q = 14'(prod >> 16);
      end
      4'd6: begin
        prod = 32'(num) * 32'd21846;
        q = 14'(prod >> 18);
      end
      4'd9: begin
        prod = 32'(num) * 32'd29128;
        q = 14'(prod >> 19);
      end
      default: q = '0;
    endcase
    return q[7:0];
  endfunction

endpackage

// ----- rtl/core/bb3_lane.sv -----
// One color channel: sums the selected window taps and rounds the mean.
module bb3_lane (
  input  logic clk,
  input  logic [7:0] taps [9],
  input  bb3_pkg::nbr_mask_t mask,
  input  logic load,
  output logic [7:0] mean
);

  logic [11:0] sum;
  logic [11:0] sum_q;
  logic [3:0] count_q;

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        if ((k != 0 || mask.top_ok) && (k != 2 || mask.bot_ok) &&
            (d != 0 || mask.left_ok) && (d != 2 || mask.right_ok)) begin
          sum = sum + 12'(taps[k * 3 + d]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_q <= sum;
      count_q <= mask.count;
    end
  end

  assign mean = bb3_pkg::round_mean(sum_q, count_q);

endmodule

// ----- rtl/core/bb3_merge.sv -----
// Packs the three lane results with the frame flag into one output word,
// with a skid register so the input side keeps running under a stall.
module bb3_merge (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic last_in,
  output logic room,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic m_axis_tlast
);

  logic skid_valid;
  logic [24:0] skid;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!m_axis_tvalid || m_axis_tready) begin
        if (skid_valid) begin
          m_axis_tvalid <= 1'b1;
          {m_axis_tlast, m_axis_tdata} <= skid;
          skid_valid <= 1'b0;
        end else begin
          m_axis_tvalid <= in_valid;
          {m_axis_tlast, m_axis_tdata} <= {last_in, blue, green, red};
        end
      end else if (in_valid) begin
        skid_valid <= 1'b1;
        skid <= {last_in, blue, green, red};
      end
    end
  end

endmodule

// ----- rtl/core/box_blur_3x3_edge_aware.sv -----
// Streaming 3x3 box blur over RGB pixels in raster order.
// Slave channel s_axis: tdata = {blue, green, red}; tuser = opcode
// (0 pixel, 1 flush tick). Master channel m_axis: tdata = {blue, green, red}
// blurred, tlast marks the last pixel of the frame.
// Configuration: cfg_we, cfg_index (0 width, 1 height), cfg_data; a write
// restarts the frame. Write only while idle.
// A request is taken every clock while neither of the two requests ahead
// of it yields a result and the receiver does not stall; while results
// flow, tready drops whenever stages 1 and 2 both hold a request. The
// result for a pixel comes from the request that arrives image_width + 1
// requests later; after the last pixel, flush ticks drain the remaining
// results. A result passes a line store read, a registered window sum in
// three channel lanes, and the output register before it is valid on
// m_axis. Reset clears positions and counters; the line stores are
// cleared by a pass over all 1024 columns after reset during which no
// request is taken. When the receiver stalls, a skid register holds one
// result and s_axis tready drops until it drains; no result is lost.
module box_blur_3x3_edge_aware (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic s_axis_tuser,          // opcode
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic m_axis_tlast,          // frame_end
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CW = bb3_pkg::ColW;

  logic [bb3_pkg::WidthW-1:0] image_width;
  logic [bb3_pkg::HeightW-1:0] image_height;
  logic [CW:0] w_eff;
  logic [bb3_pkg::RowW-1:0] h_eff;

  logic [CW:0] clear_cnt;
  logic clearing;

  bb3_pkg::pixel_t upper_mem [bb3_pkg::MaxLine];
  bb3_pkg::pixel_t middle_mem [bb3_pkg::MaxLine];

  logic [CW-1:0] in_column;
  logic [bb3_pkg::RowW-1:0] in_row;
  logic [CW-1:0] out_column;
  logic [bb3_pkg::RowW-1:0] out_row;
  logic input_complete;

  // Stage 1 (read) registers.
  logic s1_valid;
  logic s1_emit;
  logic s1_first;
  logic [CW-1:0] s1_col;
  bb3_pkg::pixel_t s1_v;
  bb3_pkg::nbr_mask_t s1_mask;
  logic s1_last;

  bb3_pkg::pixel_t upper_rd, middle_rd;
  bb3_pkg::pixel_t win [9];
  bb3_pkg::pixel_t win_next [9];

  logic s2_valid;
  logic s2_last;
  logic room;

  logic accept, active, flush_only, emit;
  logic [CW-1:0] c;
  bb3_pkg::pixel_t v;
  bb3_pkg::nbr_mask_t mask;
  logic last;
  logic [CW:0] c_inc;
  logic [bb3_pkg::RowW-1:0] oc_plus, or_plus;
  logic [2:0] nrows, ncols;
  logic fwd_up, fwd_mid;
  logic [CW-1:0] wr_addr;
  bb3_pkg::pixel_t up_data, mid_data;
  logic wr_en;

  always_comb begin
    if (image_width == '0) w_eff = (CW + 1)'(1);
    else if (image_width > bb3_pkg::WidthW'(bb3_pkg::MaxLine)) w_eff = (CW + 1)'(bb3_pkg::MaxLine);
    else w_eff = (CW + 1)'(image_width);
    if (image_height == '0) h_eff = bb3_pkg::RowW'(1);
    else if (image_height > bb3_pkg::HeightW'(bb3_pkg::HeightLimit))
      h_eff = bb3_pkg::RowW'(bb3_pkg::HeightLimit);
    else h_eff = bb3_pkg::RowW'(image_height);
  end

  assign clearing = !clear_cnt[CW];
  assign s_axis_tready = !clearing && room;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign flush_only = !input_complete && (s_axis_tuser == bb3_pkg::OP_FLUSH);
  assign active = accept && !flush_only;
  assign v = input_complete ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign c = ((CW + 1)'(in_column) >= w_eff) ? '0 : in_column;
  assign emit = (in_row >= bb3_pkg::RowW'(2)) || (in_row == bb3_pkg::RowW'(1) && c != '0);
  assign c_inc = (CW + 1)'(c) + (CW + 1)'(1);
  assign oc_plus = bb3_pkg::RowW'(out_column) + bb3_pkg::RowW'(1);
  assign or_plus = out_row + bb3_pkg::RowW'(1);

  always_comb begin
    mask.top_ok = out_row != '0;
    mask.bot_ok = or_plus < h_eff;
    mask.left_ok = out_column != '0;
    mask.right_ok = oc_plus < bb3_pkg::RowW'(w_eff);
    nrows = 3'd1 + 3'(mask.top_ok) + 3'(mask.bot_ok);
    ncols = 3'd1 + 3'(mask.left_ok) + 3'(mask.right_ok);
    unique case ({nrows[1:0], ncols[1:0]})
      4'b0101: mask.count = 4'd1;
      4'b0110, 4'b1001: mask.count = 4'd2;
      4'b0111, 4'b1101: mask.count = 4'd3;
      4'b1010: mask.count = 4'd4;
      4'b1011, 4'b1110: mask.count = 4'd6;
      4'b1111: mask.count = 4'd9;
      default: mask.count = 4'd1;
    endcase
  end

  assign last = (or_plus >= h_eff) && (oc_plus >= bb3_pkg::RowW'(w_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bb3_pkg::WidthW'(640);
      image_height <= bb3_pkg::HeightW'(480);
      clear_cnt <= '0;
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
      input_complete <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (clearing) clear_cnt <= clear_cnt + (CW + 1)'(1);
      s1_valid <= active;
      if (cfg_we) begin
        unique case (cfg_index)
          bb3_pkg::REG_WIDTH: image_width <= cfg_data[bb3_pkg::WidthW-1:0];
          bb3_pkg::REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        in_column <= '0;
        in_row <= '0;
        out_column <= '0;
        out_row <= '0;
        input_complete <= 1'b0;
      end else if (active) begin
        if (c_inc >= w_eff) begin
          in_column <= '0;
          in_row <= in_row + bb3_pkg::RowW'(1);
          if (!input_complete && (in_row + bb3_pkg::RowW'(1)) >= h_eff) input_complete <= 1'b1;
        end else begin
          in_column <= c_inc[CW-1:0];
        end
        if (emit) begin
          if (last) begin
            in_column <= '0;
            in_row <= '0;
            out_column <= '0;
            out_row <= '0;
            input_complete <= 1'b0;
          end else if (oc_plus >= bb3_pkg::RowW'(w_eff)) begin
            out_column <= '0;
            out_row <= or_plus;
          end else begin
            out_column <= oc_plus[CW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      s1_emit <= emit;
      s1_first <= (c == '0);
      s1_col <= c;
      s1_v <= v;
      s1_mask <= mask;
      s1_last <= last;
    end
  end

  // Line stores: read in stage 0, written in stage 1 with the shifted data.
  // A same-column write in flight is forwarded (one-column lines).
  assign wr_en = clearing || s1_valid;
  assign wr_addr = clearing ? clear_cnt[CW-1:0] : s1_col;

  always_ff @(posedge clk) begin
    upper_rd <= upper_mem[c];
    middle_rd <= middle_mem[c];
    fwd_up <= s1_valid && s1_col == c;
    fwd_mid <= s1_valid && s1_col == c;
    if (wr_en) begin
      upper_mem[wr_addr] <= up_data;
      middle_mem[wr_addr] <= mid_data;
    end
  end

  bb3_pkg::pixel_t upper_fwd_q, middle_fwd_q;
  bb3_pkg::pixel_t up_cur, mid_cur;
  assign up_cur = fwd_up ? upper_fwd_q : upper_rd;
  assign mid_cur = fwd_mid ? middle_fwd_q : middle_rd;

  always_ff @(posedge clk) begin
    upper_fwd_q <= clearing ? '0 : mid_cur;
    middle_fwd_q <= s1_v;
  end

  assign up_data = clearing ? '0 : mid_cur;
  assign mid_data = clearing ? '0 : s1_v;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k * 3 + 0] = win[k * 3 + 1];
      win_next[k * 3 + 1] = win[k * 3 + 2];
    end
    win_next[2] = up_cur;
    win_next[5] = mid_cur;
    win_next[8] = s1_v;
  end

  // Lane taps: centered on slot 2 of the old window at column zero,
  // otherwise on slot 1 of the shifted window.
  logic [7:0] taps_r [9], taps_g [9], taps_b [9];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        bb3_pkg::pixel_t px;
        px = '0;
        if (s1_first) begin
          if (d < 2) px = win[k * 3 + d + 1];
        end else begin
          px = win_next[k * 3 + d];
        end
        taps_r[k * 3 + d] = px[23:16];
        taps_g[k * 3 + d] = px[15:8];
        taps_b[k * 3 + d] = px[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        for (int i = 0; i < 9; i++) win[i] <= win_next[i];
      end
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) s2_last <= s1_last;
  end

  logic lane_load;
  logic [7:0] mean_r, mean_g, mean_b;
  assign lane_load = s1_valid && s1_emit;

  bb3_lane u_red (.clk, .taps(taps_r), .mask(s1_mask), .load(lane_load), .mean(mean_r));
  bb3_lane u_green (.clk, .taps(taps_g), .mask(s1_mask), .load(lane_load), .mean(mean_g));
  bb3_lane u_blue (.clk, .taps(taps_b), .mask(s1_mask), .load(lane_load), .mean(mean_b));

  // Room must cover the results already in the two stages behind the skid.
  logic merge_room;
  assign room = merge_room && !(s1_valid && s2_valid) &&
                !(m_axis_tvalid && !m_axis_tready && (s1_valid || s2_valid));

  bb3_merge u_merge (
    .clk,
    .rst,
    .in_valid(s2_valid),
    .red(mean_r),
    .green(mean_g),
    .blue(mean_b),
    .last_in(s2_last),
    .room(merge_room),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule

// ----- bench/box_blur_3x3_edge_aware_tb.sv -----
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_tb;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = bb3_pkg::REG_WIDTH;
  logic [12:0] cfg_data = '0;

  box_blur_3x3_edge_aware uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  logic [10:0] p_width;
  logic [12:0] p_height;
  bb3_pkg::pixel_t upper_mem [bb3_pkg::MaxLine];
  bb3_pkg::pixel_t middle_mem [bb3_pkg::MaxLine];
  bb3_pkg::pixel_t win [9];
  int unsigned in_col, in_row, out_col, out_row;
  bit in_done;

  pix_req_t  pend_reqs[$];
  blur_res_t blur_exp[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int frames_done = 0;
  int src_idle = 0;
  int sink_stall = 0;
  int hold_left = 0;
  bit in_taken = 1'b0;

  function automatic int unsigned w_eff();
    if (p_width == 0) return 1;
    if (p_width > bb3_pkg::MaxLine) return bb3_pkg::MaxLine;
    return p_width;
  endfunction

  function automatic int unsigned h_eff();
    if (p_height == 0) return 1;
    if (p_height > bb3_pkg::HeightLimit) return bb3_pkg::HeightLimit;
    return p_height;
  endfunction

  function automatic void restart_pos();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;
  endfunction

  function automatic blur_res_t blur_mean(int base, int unsigned w, int unsigned h);
    int unsigned sr, sg, sb, n;
    int slot;
    blur_res_t res;
    sr = 0; sg = 0; sb = 0; n = 0;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      if (k == 0 && out_row == 0) continue;
      if (k == 2 && out_row + 1 >= h) continue;
      for (int d = -1; d <= 1; d++) begin
        if (d < 0 && out_col == 0) continue;
        if (d > 0 && out_col + 1 >= w) continue;
        slot = base + d;
        if (slot < 0 || slot > 2) continue;
        sr += win[k*3+slot][23:16];
        sg += win[k*3+slot][15:8];
        sb += win[k*3+slot][7:0];
        n++;
      end
    end
    if (n != 0) begin
      res.red = 8'((2*sr + n) / (2*n));
      res.green = 8'((2*sg + n) / (2*n));
      res.blue = 8'((2*sb + n) / (2*n));
    end
    return res;
  endfunction

  task automatic predict_blur(input pix_req_t rq);
    int unsigned w, h, c, r;
    bb3_pkg::pixel_t v, up, mid;
    bit emit;
    blur_res_t res;
    w = w_eff(); h = h_eff();
    res = '0;
    if (!in_done) begin
      if (rq.op == bb3_pkg::OP_FLUSH) return;
      v = {rq.red, rq.green, rq.blue};
    end else v = '0;
    c = (in_col >= w) ? 0 : in_col;
    r = in_row;
    emit = (r >= 2) || (r == 1 && c >= 1);
    up = upper_mem[c];
    mid = middle_mem[c];
    upper_mem[c] = mid;
    middle_mem[c] = v;
    if (emit && c == 0) res = blur_mean(2, w, h);
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up; win[5] = mid; win[8] = v;
    if (emit && c != 0) res = blur_mean(1, w, h);
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = r + 1;
      if (!in_done && in_row >= h) in_done = 1'b1;
    end
    if (!emit) return;
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) restart_pos();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    blur_exp.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_recv, what, got, want);
    errors++;
  endtask

  // Input handshakes are taken at the rising edge and fed to the predictor.
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_blur(pend_reqs.pop_front());
      n_sent++;
    end
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Driver: offers the head of the pending queue with random gaps and holds
  // an offered request until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !in_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (pend_reqs.size() != 0 &&
                   !(src_idle > 0 && $urandom_range(99) < src_idle)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pend_reqs[0].op;
        s_axis_tdata <= {pend_reqs[0].blue, pend_reqs[0].green, pend_reqs[0].red};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= (hold_left == 0) && !(sink_stall > 0 && $urandom_range(99) < sink_stall);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    blur_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (blur_exp.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = blur_exp.pop_front();
        if (m_axis_tdata[7:0] != want.red) report_mismatch("red", m_axis_tdata[7:0], want.red);
        if (m_axis_tdata[15:8] != want.green)
          report_mismatch("green", m_axis_tdata[15:8], want.green);
        if (m_axis_tdata[23:16] != want.blue)
          report_mismatch("blue", m_axis_tdata[23:16], want.blue);
        if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
        if (want.last) frames_done++;
      end
      n_recv++;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bb3_pkg::REG_WIDTH) p_width = val[10:0];
    else p_height = val;
    restart_pos();
  endtask

  task automatic wait_drain();
    while (pend_reqs.size() != 0 || s_axis_tvalid || blur_exp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic pix_req_t rand_pixel();
    pix_req_t p;
    p.op = bb3_pkg::OP_PIXEL;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    if ($urandom_range(9) == 0) p.red = 8'hFF;
    if ($urandom_range(9) == 0) p.blue = 8'h00;
    return p;
  endfunction

  // One frame of pixels, then flush ticks to drain it; noise is mixed in.
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy);
    pix_req_t p;
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(15) == 0) begin
        p = rand_pixel();
        p.op = bb3_pkg::OP_FLUSH;
        pend_reqs.push_back(p);
      end
      pend_reqs.push_back(rand_pixel());
    end
    for (int i = 0; i < w + 1; i++) begin
      p = rand_pixel();
      // A pixel after the frame's end acts as a flush tick.
      if (!(noisy && $urandom_range(3) == 0)) p.op = bb3_pkg::OP_FLUSH;
      pend_reqs.push_back(p);
    end
  endtask

  task automatic run_frame(input logic [10:0] w, input logic [12:0] h, input bit noisy);
    int unsigned we, he;
    write_reg(bb3_pkg::REG_WIDTH, 13'(w));
    write_reg(bb3_pkg::REG_HEIGHT, h);
    we = w_eff(); he = h_eff();
    queue_frame(we, he, noisy);
    wait_drain();
  endtask

  initial begin
    pix_req_t p;
    int total;
    p_width = 11'd640;
    p_height = 13'd480;
    for (int i = 0; i < bb3_pkg::MaxLine; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    restart_pos();
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: flush before any pixel, extremes, 0 width and height (1x1), 1x4, 4x1.
    write_reg(bb3_pkg::REG_WIDTH, 13'd3);
    write_reg(bb3_pkg::REG_HEIGHT, 13'd3);
    p = pix_req_t'{bb3_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF};
    pend_reqs.push_back(p);
    for (int i = 0; i < 9; i++) begin
      if (i % 2) p = pix_req_t'{bb3_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF};
      else p = pix_req_t'{bb3_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00};
      pend_reqs.push_back(p);
    end
    p = pix_req_t'{bb3_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00};
    for (int i = 0; i < 4; i++) pend_reqs.push_back(p);
    wait_drain();
    run_frame(11'd0, 13'd0, 1'b0);
    run_frame(11'd1, 13'd4, 1'b0);
    run_frame(11'd4, 13'd1, 1'b0);

    total = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 22) : 0;
      sink_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 59 : 22) : 0;
      while (total < (ph + 1) * 70) begin
        int unsigned w, h;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        total += w * h;
        run_frame(11'(w), 13'(h), 1'b1);
      end
    end

    // Long receiver hold-off while the sender keeps offering.
    src_idle = 0; sink_stall = 0;
    write_reg(bb3_pkg::REG_WIDTH, 13'd4);
    write_reg(bb3_pkg::REG_HEIGHT, 13'd5);
    queue_frame(4, 5, 1'b0);
    hold_left = 200;
    wait (hold_left == 0);
    wait_drain();

    $display("Sent %0d requests and checked %0d results over %0d frames,", n_sent, n_recv,
             frames_done);
    $display("covering edge masks, flush drains, degenerate sizes and backpressure.");
    if (errors == 0 && blur_exp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
